// ===== src/sgb_pkg.sv =====
`timescale 1ns / 1ps
package sgb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_last;
    } out_item_t;

    // Work handed from the front to the back part: one stream step.
    // The mask bits enable the horizontal taps at offsets -2, -1, +1 and +2.
    typedef struct packed {
        logic             real_pix;
        logic [7:0]       pix;
        logic [DIM_W-1:0] in_row;
        logic [COL_W-1:0] in_col;
        logic             emit;
        logic             last;
        logic [3:0]       hmask;
    } step_t;

    // Weighted average floor((2*dot+sum)/(2*sum)). The tap weight totals that
    // can occur are 16, 15, 14, 11, 10 and 6; each divisor is a reciprocal
    // multiply that is exact over the whole numerator range.
    function automatic logic [7:0] wavg(input logic [11:0] dot, input logic [4:0] sum);
        logic [13:0] num;
        logic [31:0] q;
        begin
            num = {1'b0, dot, 1'b0} + 14'(sum);
            case (sum)
                5'd16:   q = 32'(num) >> 5;
                5'd15:   q = (32'(num) * 32'd34953) >> 20;
                5'd14:   q = (32'(num) * 32'd37450) >> 20;
                5'd11:   q = (32'(num) * 32'd47663) >> 20;
                5'd10:   q = (32'(num) * 32'd52429) >> 20;
                5'd6:    q = (32'(num) * 32'd87382) >> 20;
                default: q = '0;
            endcase
            wavg = q[7:0];
        end
    endfunction

endpackage

// ===== src/sgb_front.sv =====
`timescale 1ns / 1ps
module sgb_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       clr,
    input  logic [sgb_pkg::DIM_W-1:0]  w,
    input  logic [sgb_pkg::DIM_W-1:0]  h,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  sgb_pkg::in_item_t          s_data,
    output logic                       q_valid,
    input  logic                       q_ready,
    output sgb_pkg::step_t             q_data
);
    import sgb_pkg::*;

    logic [DIM_W-1:0] in_col_reg, in_row_reg, out_col_reg, out_row_reg;
    logic [21:0]      vpos_reg;
    logic             done, emit, last, take;
    logic [DIM_W:0]   thr;
    logic             q_valid_reg;
    step_t            q_data_reg;
    step_t            step_next;

    assign done    = in_row_reg >= h;
    assign thr     = {w, 1'b0} + 12'd2;
    assign emit    = (vpos_reg >= 22'(thr)) && (out_row_reg < h);
    assign last    = emit && (out_row_reg == h - 1'b1) && (out_col_reg == w - 1'b1);
    assign s_ready = !q_valid_reg || q_ready;
    assign take    = s_valid && s_ready && (done || s_data.action == ACT_PIXEL);
    assign q_valid = q_valid_reg;
    assign q_data  = q_data_reg;

    always_comb begin
        step_next.real_pix = !done;
        step_next.pix      = s_data.pixel_in;
        step_next.in_row   = in_row_reg;
        step_next.in_col   = in_col_reg[COL_W-1:0];
        step_next.emit     = emit;
        step_next.last     = last;
        step_next.hmask[0] = out_col_reg >= 11'd2;
        step_next.hmask[1] = out_col_reg >= 11'd1;
        step_next.hmask[2] = (out_col_reg + 11'd1) < w;
        step_next.hmask[3] = (out_col_reg + 11'd2) < w;
    end

    // The one-entry queue register decouples classification from the back part.
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            in_col_reg <= '0; in_row_reg <= '0; out_col_reg <= '0;
            out_row_reg <= '0; vpos_reg <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            if (s_ready) q_valid_reg <= take;
            if (take) begin
                q_data_reg <= step_next;
                if (last) begin
                    in_col_reg <= '0; in_row_reg <= '0; out_col_reg <= '0;
                    out_row_reg <= '0; vpos_reg <= '0;
                end else begin
                    vpos_reg <= vpos_reg + 22'd1;
                    if (in_col_reg + 1'b1 >= w) begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + 1'b1;
                    end else begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                    if (emit) begin
                        if (out_col_reg + 1'b1 >= w) begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 1'b1;
                        end else begin
                            out_col_reg <= out_col_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end
endmodule

// ===== src/sgb_back.sv =====
`timescale 1ns / 1ps
module sgb_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [sgb_pkg::DIM_W-1:0]  w,
    input  logic [sgb_pkg::DIM_W-1:0]  h,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  sgb_pkg::step_t             q_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output sgb_pkg::out_item_t         m_data
);
    import sgb_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_VERT, ST_HORZ, ST_OUT} state_t;

    state_t           state_reg;
    step_t            st_reg;
    logic [1:0]       rd_cnt_reg;
    logic [7:0]       mem [0:4*MAX_WIDTH-1];
    logic [7:0]       rd_reg [0:3];
    logic [7:0]       win_reg [0:3];
    logic [7:0]       vert_reg;
    out_item_t        out_reg;
    logic [7:0]       vert;
    logic [7:0]       hres;
    logic [11:0]      vdot, hdot;
    logic [4:0]       vsum, hsum;
    logic [DIM_W-1:0] rr;

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;

    always_comb begin
        vdot = '0; vsum = '0;
        for (int k = 0; k < 5; k++) begin
            rr = st_reg.in_row + DIM_W'(k) - 11'd4;
            if ((st_reg.in_row + DIM_W'(k) >= 11'd4) && (rr < h)) begin
                if (k == 4) begin
                    vdot = vdot + 12'(st_reg.pix);
                end else if (k == 0 || k == 3) begin
                    vdot = vdot + 12'(rd_reg[2'(k)]) * 12'((k == 0) ? 1 : 4);
                end else begin
                    vdot = vdot + 12'(rd_reg[2'(k)]) * 12'((k == 1) ? 4 : 6);
                end
                vsum = vsum + 5'((k == 0 || k == 4) ? 1 : (k == 2 ? 6 : 4));
            end
        end
        if (st_reg.in_row >= 11'd2 && st_reg.in_row - 11'd2 < h) begin
            vert = wavg(vdot, vsum);
        end else begin
            vert = '0;
        end
    end

    // The window still holds the four older vertical results; the newest one
    // sits in vert_reg until the window shifts at the end of this step.
    always_comb begin
        hdot = 12'(win_reg[2]) * 12'd6;
        hsum = 5'd6;
        if (st_reg.hmask[0]) begin
            hdot = hdot + 12'(win_reg[0]); hsum = hsum + 5'd1;
        end
        if (st_reg.hmask[1]) begin
            hdot = hdot + 12'(win_reg[1]) * 12'd4; hsum = hsum + 5'd4;
        end
        if (st_reg.hmask[2]) begin
            hdot = hdot + 12'(win_reg[3]) * 12'd4; hsum = hsum + 5'd4;
        end
        if (st_reg.hmask[3]) begin
            hdot = hdot + 12'(vert_reg); hsum = hsum + 5'd1;
        end
        hres = wavg(hdot, hsum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_cnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: if (q_valid) state_reg <= ST_READ;
                ST_READ: begin
                    rd_cnt_reg <= rd_cnt_reg + 2'd1;
                    if (rd_cnt_reg == 2'd3) state_reg <= ST_VERT;
                end
                ST_VERT: state_reg <= ST_HORZ;
                ST_HORZ: begin
                    if (st_reg.emit) begin
                        out_reg.pixel_out  <= hres;
                        out_reg.frame_last <= st_reg.last;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:  if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Line store: one registered read per cycle, written after the reads.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            rd_reg[rd_cnt_reg] <= mem[{2'(st_reg.in_row[1:0] + rd_cnt_reg), st_reg.in_col}];
        end
        if (state_reg == ST_VERT && st_reg.real_pix) begin
            mem[{st_reg.in_row[1:0], st_reg.in_col}] <= st_reg.pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) st_reg <= q_data;
        if (state_reg == ST_VERT) vert_reg <= vert;
        if (state_reg == ST_HORZ) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= vert_reg;
        end
    end
endmodule

// ===== src/separable_gaussian_blur_5tap.sv =====
`timescale 1ns / 1ps
// 5x5 binomial blur with weights 1,4,6,4,1, done as a vertical pass and then a
// horizontal pass. Pixels enter in raster order as requests; taps outside the
// image are dropped and each pass divides by the weights actually used,
// rounding half up. Output pixel m leaves with stream position m + 2*W + 2, so
// after the last pixel the user sends drain requests to flush the frame;
// frame_last marks the final pixel and then every position counter returns to
// zero. Drain requests before the frame's input ends are accepted and dropped.
// A configuration write restarts the frame and must only be done while nothing
// is in flight. The front accepts a request into a one-entry queue, and the
// back part then handles each step in turn (take from the queue, four
// single-port line store reads, vertical pass, horizontal pass), followed by
// the output stage, held until m_ready, when the step produces a result. The
// back part takes the next step from the queue only once it is idle again, so
// a request accepted meanwhile waits in the one-entry queue.
module separable_gaussian_blur_5tap (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [10:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sgb_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sgb_pkg::out_item_t    m_data
);
    import sgb_pkg::*;

    logic [DIM_W-1:0] wreg_reg, hreg_reg, w, h;
    logic             q_valid, q_ready;
    step_t            q_data;

    assign w = (wreg_reg == 0) ? 11'd1 : (wreg_reg > 11'(MAX_WIDTH) ? 11'(MAX_WIDTH) : wreg_reg);
    assign h = (hreg_reg == 0) ? 11'd1 : (hreg_reg > 11'(MAX_HEIGHT) ? 11'(MAX_HEIGHT) : hreg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wreg_reg <= 11'd1; hreg_reg <= 11'd1;
        end else if (cfg_we) begin
            if (cfg_index == REG_WIDTH) wreg_reg <= cfg_data;
            else hreg_reg <= cfg_data;
        end
    end

    sgb_front u_front (.aclk, .aresetn, .clr(cfg_we), .w, .h, .s_valid, .s_ready,
        .s_data, .q_valid, .q_ready, .q_data);
    sgb_back u_back (.aclk, .aresetn, .w, .h, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data);
endmodule

// ===== src/sgb_checker.sv =====
`timescale 1ns / 1ps
module sgb_checker (
    input logic aclk, input logic aresetn,
    input logic s_valid, input logic s_ready,
    input logic m_valid, input logic m_ready,
    input sgb_pkg::out_item_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("m_valid dropped");
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data)) else $error("m_data changed while waiting");
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid) else $error("s_valid dropped");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule
bind separable_gaussian_blur_5tap sgb_checker u_chk (.aclk, .aresetn,
    .s_valid, .s_ready, .m_valid, .m_ready, .m_data);
